FILE: src/qs_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helper functions for the quaternion slerp pipeline.
// Depends on nothing; qs_cordic_cell, qs_div_cell and quaternion_slerp use it by scoped names.
package qs_pkg;

    localparam int COMPONENT_BITS = 16;
    localparam int CORDIC_STEPS   = 16;
    localparam int FRAC_BITS      = COMPONENT_BITS - 2;
    localparam int W_SHIFT        = 32 - COMPONENT_BITS;
    localparam int CW             = 40;
    localparam int STEP_W         = 5;
    localparam int DSTEP_W        = $clog2(COMPONENT_BITS);
    localparam int SQRT_STEPS     = 32;
    localparam int LATENCY        = 4 + 2 * SQRT_STEPS + 2 * CORDIC_STEPS + 3 + 5 + 1
                                    + COMPONENT_BITS;

    localparam logic signed [31:0]   ONE_W     = 32'sh4000_0000;
    localparam logic signed [CW-1:0] HALF_PI_W = 40'sd1686629713;
    localparam logic signed [CW-1:0] PI_W      = 40'sd3373259426;
    localparam logic signed [CW-1:0] GAIN_W    = 40'sd652032874;
    localparam logic [31:0]          HALF_PI_U = 32'd1686629713;
    localparam logic [31:0]          PI_U      = 32'd3373259426;
    localparam logic [32:0]          SMALL_SIN = 33'd1048576;
    localparam logic [16:0]          T_ONE     = 17'd65536;

    typedef enum logic [1:0] {
        STATUS_NORMAL = 2'd0,
        STATUS_SMALL  = 2'd1,
        STATUS_ZERO   = 2'd2
    } status_t;

    // Operands and blend factor travelling with the front half of the pipeline.
    typedef struct packed {
        logic [3:0][COMPONENT_BITS-1:0] a;
        logic [3:0][COMPONENT_BITS-1:0] b;
        logic [30:0]                    t30;
        logic                           fallback;
    } side_t;

    // Interpolated components and flags travelling through the norm square root.
    typedef struct packed {
        logic [3:0][33:0] r;
        logic             fallback;
        logic             zero;
    } back_t;

    // Flags travelling through the divider lanes.
    typedef struct packed {
        logic [3:0] neg;
        logic       fallback;
        logic       zero;
    } tail_t;

    function automatic logic signed [31:0] to_w(input logic signed [COMPONENT_BITS-1:0] v);
        to_w = 32'(v) <<< W_SHIFT;
    endfunction

    function automatic logic signed [CW-1:0] atan_w(input logic [STEP_W-1:0] i);
        case (i)
            5'd0:    atan_w = 40'sd843314857;
            5'd1:    atan_w = 40'sd497837829;
            5'd2:    atan_w = 40'sd263043837;
            5'd3:    atan_w = 40'sd133525159;
            5'd4:    atan_w = 40'sd67021687;
            5'd5:    atan_w = 40'sd33543516;
            5'd6:    atan_w = 40'sd16775851;
            5'd7:    atan_w = 40'sd8388437;
            5'd8:    atan_w = 40'sd4194283;
            5'd9:    atan_w = 40'sd2097149;
            5'd31:   atan_w = '0;
            default: atan_w = CW'(1) <<< (5'd30 - i);
        endcase
    endfunction

    function automatic logic [63:0] sqrt_bit(input int k);
        sqrt_bit = 64'(1) << (62 - 2 * k);
    endfunction

endpackage

FILE: src/qs_sqrt_cell.sv
`timescale 1ns / 1ps
// One restoring step of a 64-bit integer square root, registered.
// Depends on nothing beyond its ports.
module qs_sqrt_cell (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] rad_in,
    input  logic [63:0] root_in,
    input  logic [63:0] bit_in,
    output logic [63:0] rad_out,
    output logic [63:0] root_out
);

    logic [63:0] rad_reg, root_reg;
    logic [63:0] rad_next, root_next, trial;

    always_comb
    begin
        trial = root_in + bit_in;
        if (rad_in >= trial)
        begin
            rad_next  = rad_in - trial;
            root_next = (root_in >> 1) + bit_in;
        end
        else
        begin
            rad_next  = rad_in;
            root_next = root_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= rad_next;
            root_reg <= root_next;
        end
    end

    assign rad_out  = rad_reg;
    assign root_out = root_reg;

endmodule

FILE: src/qs_cordic_cell.sv
`timescale 1ns / 1ps
// One CORDIC micro-rotation, in vectoring or rotation mode, registered.
// Depends on qs_pkg for widths and the arctangent table.
module qs_cordic_cell (
    input  logic                             clk,
    input  logic                             en,
    input  logic                             vectoring,
    input  logic [qs_pkg::STEP_W-1:0]        step,
    input  logic signed [qs_pkg::CW-1:0]     x_in,
    input  logic signed [qs_pkg::CW-1:0]     y_in,
    input  logic signed [qs_pkg::CW-1:0]     z_in,
    output logic signed [qs_pkg::CW-1:0]     x_out,
    output logic signed [qs_pkg::CW-1:0]     y_out,
    output logic signed [qs_pkg::CW-1:0]     z_out
);

    logic signed [qs_pkg::CW-1:0] x_reg, y_reg, z_reg;
    logic signed [qs_pkg::CW-1:0] x_next, y_next, z_next, xs, ys, at;
    logic ccw;

    always_comb
    begin
        xs  = x_in >>> step;
        ys  = y_in >>> step;
        at  = qs_pkg::atan_w(step);
        // Vectoring drives y toward zero, rotation drives z toward zero.
        ccw = vectoring ? y_in[qs_pkg::CW-1] : !z_in[qs_pkg::CW-1];
        if (ccw)
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - at;
        end
        else
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + at;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

FILE: src/qs_div_cell.sv
`timescale 1ns / 1ps
// One restoring division step producing a single quotient bit, registered.
// Depends on qs_pkg for the component width.
module qs_div_cell (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic [qs_pkg::DSTEP_W-1:0]           step,
    input  logic [63:0]                          rem_in,
    input  logic [32:0]                          den_in,
    input  logic [qs_pkg::COMPONENT_BITS-1:0]    quo_in,
    output logic [63:0]                          rem_out,
    output logic [32:0]                          den_out,
    output logic [qs_pkg::COMPONENT_BITS-1:0]    quo_out
);

    logic [63:0] rem_reg, rem_next, dshift;
    logic [32:0] den_reg;
    logic [qs_pkg::COMPONENT_BITS-1:0] quo_reg, quo_next;

    always_comb
    begin
        dshift = 64'(den_in) << step;
        if (rem_in >= dshift)
        begin
            rem_next = rem_in - dshift;
            quo_next = quo_in | (qs_pkg::COMPONENT_BITS'(1) << step);
        end
        else
        begin
            rem_next = rem_in;
            quo_next = quo_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            den_reg <= den_in;
            quo_reg <= quo_next;
        end
    end

    assign rem_out = rem_reg;
    assign den_out = den_reg;
    assign quo_out = quo_reg;

endmodule

FILE: src/quaternion_slerp.sv
`timescale 1ns / 1ps
// Quaternion slerp, fully pipelined: a new word is taken on every clock while
// in_ready is high. The chain holds two 32-step square roots, an angle CORDIC
// and a sine CORDIC pair of CORDIC_STEPS cells each, a divider of COMPONENT_BITS
// cells, and fourteen single-stage multiply, sum and format steps. The whole
// chain advances together and only holds when a result sits in the output
// register and out_ready is low, so in_ready simply follows that condition.
// status reports a linear fallback for small sin(theta), near zero or a half
// turn, or a zero-length result; the latter forces all components to zero.
// Depends on qs_pkg, qs_sqrt_cell, qs_cordic_cell and qs_div_cell.
module quaternion_slerp (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [qs_pkg::COMPONENT_BITS-1:0] a_x,
    input  logic signed [qs_pkg::COMPONENT_BITS-1:0] a_y,
    input  logic signed [qs_pkg::COMPONENT_BITS-1:0] a_z,
    input  logic signed [qs_pkg::COMPONENT_BITS-1:0] a_w,
    input  logic signed [qs_pkg::COMPONENT_BITS-1:0] b_x,
    input  logic signed [qs_pkg::COMPONENT_BITS-1:0] b_y,
    input  logic signed [qs_pkg::COMPONENT_BITS-1:0] b_z,
    input  logic signed [qs_pkg::COMPONENT_BITS-1:0] b_w,
    input  logic [16:0]                             blend_t,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [qs_pkg::COMPONENT_BITS-1:0] out_x,
    output logic signed [qs_pkg::COMPONENT_BITS-1:0] out_y,
    output logic signed [qs_pkg::COMPONENT_BITS-1:0] out_z,
    output logic signed [qs_pkg::COMPONENT_BITS-1:0] out_w,
    output logic [1:0]                              status
);

    localparam int CB  = qs_pkg::COMPONENT_BITS;
    localparam int CS  = qs_pkg::CORDIC_STEPS;
    localparam int CW  = qs_pkg::CW;
    localparam int SQ  = qs_pkg::SQRT_STEPS;
    localparam int LAT = qs_pkg::LATENCY;
    localparam logic signed [CB-1:0] Q_ONE = CB'(1 << qs_pkg::FRAC_BITS);

    // The whole chain moves when the output register is free or being emptied.
    logic adv;
    logic [LAT-1:0] vld_reg;
    logic out_valid_reg;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[LAT-2:0], in_valid};
            out_valid_reg <= vld_reg[LAT-1];
        end
    end

    // Input capture with the blend fraction saturated to one and moved to Q30.
    qs_pkg::side_t s0_side_reg, s0_side_next;
    logic [16:0] tq_sat;

    always_comb
    begin
        tq_sat                = (blend_t > qs_pkg::T_ONE) ? qs_pkg::T_ONE : blend_t;
        s0_side_next.a        = {a_w, a_z, a_y, a_x};
        s0_side_next.b        = {b_w, b_z, b_y, b_x};
        s0_side_next.t30      = {tq_sat, 14'd0};
        s0_side_next.fallback = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_side_reg <= s0_side_next;
        end
    end

    // Dot product: four floored products, their clamped sum, then (1-c)(1+c).
    qs_pkg::side_t s1_side_reg, s2_side_reg, s3_side_reg;
    logic signed [63:0] s1_full [4];
    logic signed [33:0] s1_prod_reg [4];
    logic signed [35:0] s2_sum;
    logic signed [31:0] s2_dot_next, s2_dot_reg, s3_dot_reg;
    logic signed [32:0] s3_om, s3_op;
    logic [63:0] s3_p_next, s3_p_reg;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            s1_full[k] = qs_pkg::to_w(s0_side_reg.a[k]) * qs_pkg::to_w(s0_side_reg.b[k]);
        end
        s2_sum = 36'(s1_prod_reg[0]) + 36'(s1_prod_reg[1])
               + 36'(s1_prod_reg[2]) + 36'(s1_prod_reg[3]);
        if (s2_sum > 36'sd1073741824)
        begin
            s2_dot_next = qs_pkg::ONE_W;
        end
        else if (s2_sum < -36'sd1073741824)
        begin
            s2_dot_next = -qs_pkg::ONE_W;
        end
        else
        begin
            s2_dot_next = s2_sum[31:0];
        end
        s3_om     = 33'(qs_pkg::ONE_W) - 33'(s2_dot_reg);
        s3_op     = 33'(qs_pkg::ONE_W) + 33'(s2_dot_reg);
        s3_p_next = 64'(s3_om[31:0]) * 64'(s3_op[31:0]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 4; k++)
            begin
                s1_prod_reg[k] <= s1_full[k][63:30];
            end
            s1_side_reg <= s0_side_reg;
            s2_dot_reg  <= s2_dot_next;
            s2_side_reg <= s1_side_reg;
            s3_p_reg    <= s3_p_next;
            s3_dot_reg  <= s2_dot_reg;
            s3_side_reg <= s2_side_reg;
        end
    end

    // sin(theta) as the square root of (1-c)(1+c).
    logic [63:0] sq1_rad [SQ+1];
    logic [63:0] sq1_root [SQ+1];
    qs_pkg::side_t sq1_side_reg [SQ];
    logic signed [31:0] sq1_dot_reg [SQ];

    assign sq1_rad[0]  = s3_p_reg;
    assign sq1_root[0] = '0;

    for (genvar k = 0; k < SQ; k++)
    begin : g_sq1
        qs_sqrt_cell u_cell (
            .clk      (clk),
            .en       (adv),
            .rad_in   (sq1_rad[k]),
            .root_in  (sq1_root[k]),
            .bit_in   (qs_pkg::sqrt_bit(k)),
            .rad_out  (sq1_rad[k+1]),
            .root_out (sq1_root[k+1])
        );
        if (k == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    sq1_side_reg[k] <= s3_side_reg;
                    sq1_dot_reg[k]  <= s3_dot_reg;
                end
            end
        end
        else
        begin : g_rest
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    sq1_side_reg[k] <= sq1_side_reg[k-1];
                    sq1_dot_reg[k]  <= sq1_dot_reg[k-1];
                end
            end
        end
    end

    // Angle: vectoring CORDIC on (c, s), pre-rotated by a quarter turn when c < 0.
    logic [32:0] sv;
    logic signed [CW-1:0] an_x [CS+1];
    logic signed [CW-1:0] an_y [CS+1];
    logic signed [CW-1:0] an_z [CS+1];
    qs_pkg::side_t an_side_reg [CS];
    qs_pkg::side_t an_entry;

    always_comb
    begin
        sv                = sq1_root[SQ][32:0];
        an_entry          = sq1_side_reg[SQ-1];
        an_entry.fallback = sv < qs_pkg::SMALL_SIN;
        if (sq1_dot_reg[SQ-1] < 0)
        begin
            an_x[0] = CW'(sv);
            an_y[0] = -CW'(sq1_dot_reg[SQ-1]);
            an_z[0] = qs_pkg::HALF_PI_W;
        end
        else
        begin
            an_x[0] = CW'(sq1_dot_reg[SQ-1]);
            an_y[0] = CW'(sv);
            an_z[0] = '0;
        end
    end

    for (genvar k = 0; k < CS; k++)
    begin : g_ang
        qs_cordic_cell u_cell (
            .clk       (clk),
            .en        (adv),
            .vectoring (1'b1),
            .step      (qs_pkg::STEP_W'(k)),
            .x_in      (an_x[k]),
            .y_in      (an_y[k]),
            .z_in      (an_z[k]),
            .x_out     (an_x[k+1]),
            .y_out     (an_y[k+1]),
            .z_out     (an_z[k+1])
        );
        if (k == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    an_side_reg[k] <= an_entry;
                end
            end
        end
        else
        begin : g_rest
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    an_side_reg[k] <= an_side_reg[k-1];
                end
            end
        end
    end

    // Theta clamp, t*theta, and folding of both sine arguments into [0, pi/2].
    qs_pkg::side_t t1_side_reg, t2_side_reg, t3_side_reg;
    logic [31:0] t1_theta_next, t1_theta_reg;
    logic [63:0] t2_prod;
    logic [31:0] t2_tth_reg, t2_diff_reg, t3_arg_a_reg, t3_arg_b_reg;

    function automatic logic [31:0] fold_arg(input logic [31:0] v);
        fold_arg = (v > qs_pkg::HALF_PI_U) ? (qs_pkg::PI_U - v) : v;
    endfunction

    always_comb
    begin
        if (an_z[CS] < 0)
        begin
            t1_theta_next = '0;
        end
        else if (an_z[CS] > qs_pkg::PI_W)
        begin
            t1_theta_next = qs_pkg::PI_U;
        end
        else
        begin
            t1_theta_next = an_z[CS][31:0];
        end
        t2_prod = 64'(t1_theta_reg) * 64'(t1_side_reg.t30);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t1_theta_reg <= t1_theta_next;
            t1_side_reg  <= an_side_reg[CS-1];
            t2_tth_reg   <= t2_prod[61:30];
            t2_diff_reg  <= t1_theta_reg - t2_prod[61:30];
            t2_side_reg  <= t1_side_reg;
            t3_arg_a_reg <= fold_arg(t2_diff_reg);
            t3_arg_b_reg <= fold_arg(t2_tth_reg);
            t3_side_reg  <= t2_side_reg;
        end
    end

    // Two rotation CORDIC chains give sin((1-t)theta) and sin(t theta).
    logic signed [CW-1:0] sa_x [CS+1];
    logic signed [CW-1:0] sa_y [CS+1];
    logic signed [CW-1:0] sa_z [CS+1];
    logic signed [CW-1:0] sb_x [CS+1];
    logic signed [CW-1:0] sb_y [CS+1];
    logic signed [CW-1:0] sb_z [CS+1];
    qs_pkg::side_t sn_side_reg [CS];

    assign sa_x[0] = qs_pkg::GAIN_W;
    assign sa_y[0] = '0;
    assign sa_z[0] = CW'(t3_arg_a_reg);
    assign sb_x[0] = qs_pkg::GAIN_W;
    assign sb_y[0] = '0;
    assign sb_z[0] = CW'(t3_arg_b_reg);

    for (genvar k = 0; k < CS; k++)
    begin : g_sin
        qs_cordic_cell u_cell_a (
            .clk       (clk),
            .en        (adv),
            .vectoring (1'b0),
            .step      (qs_pkg::STEP_W'(k)),
            .x_in      (sa_x[k]),
            .y_in      (sa_y[k]),
            .z_in      (sa_z[k]),
            .x_out     (sa_x[k+1]),
            .y_out     (sa_y[k+1]),
            .z_out     (sa_z[k+1])
        );
        qs_cordic_cell u_cell_b (
            .clk       (clk),
            .en        (adv),
            .vectoring (1'b0),
            .step      (qs_pkg::STEP_W'(k)),
            .x_in      (sb_x[k]),
            .y_in      (sb_y[k]),
            .z_in      (sb_z[k]),
            .x_out     (sb_x[k+1]),
            .y_out     (sb_y[k+1]),
            .z_out     (sb_z[k+1])
        );
        if (k == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    sn_side_reg[k] <= t3_side_reg;
                end
            end
        end
        else
        begin : g_rest
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    sn_side_reg[k] <= sn_side_reg[k-1];
                end
            end
        end
    end

    // Weights, weighted sum rounded to Q28, squares and their sum.
    qs_pkg::side_t w_side_reg;
    logic [31:0] w_wa_next, w_wb_next, w_wa_reg, w_wb_reg;
    logic signed [65:0] m_pa_reg [4];
    logic signed [65:0] m_pb_reg [4];
    logic signed [65:0] m_pa_next [4];
    logic signed [65:0] m_pb_next [4];
    logic signed [65:0] s_sum [4];
    logic signed [33:0] s_r_reg [4];
    logic signed [33:0] q_r_reg [4];
    logic signed [67:0] q_full [4];
    logic [63:0] q_sq_reg [4];
    logic [63:0] u_sum_next;
    logic m_small_reg, s_small_reg, q_small_reg;
    qs_pkg::back_t u_back_reg, u_back_next;
    logic [63:0] u_sumsq_reg;

    always_comb
    begin
        if (sn_side_reg[CS-1].fallback)
        begin
            // Linear fallback near zero or half-turn angles.
            w_wa_next = 32'(qs_pkg::ONE_W) - 32'(sn_side_reg[CS-1].t30);
            w_wb_next = 32'(sn_side_reg[CS-1].t30);
        end
        else
        begin
            w_wa_next = sa_y[CS][CW-1] ? 32'd0 : sa_y[CS][31:0];
            w_wb_next = sb_y[CS][CW-1] ? 32'd0 : sb_y[CS][31:0];
        end
        for (int k = 0; k < 4; k++)
        begin
            m_pa_next[k] = 66'($signed({1'b0, w_wa_reg})) * 66'(qs_pkg::to_w(w_side_reg.a[k]));
            m_pb_next[k] = 66'($signed({1'b0, w_wb_reg})) * 66'(qs_pkg::to_w(w_side_reg.b[k]));
            s_sum[k]     = m_pa_reg[k] + m_pb_reg[k] + 66'sh8000_0000;
            q_full[k]    = 68'(s_r_reg[k]) * 68'(s_r_reg[k]);
        end
        u_sum_next = q_sq_reg[0] + q_sq_reg[1] + q_sq_reg[2] + q_sq_reg[3];
        for (int k = 0; k < 4; k++)
        begin
            u_back_next.r[k] = q_r_reg[k];
        end
        u_back_next.fallback = q_small_reg;
        u_back_next.zero     = u_sum_next == 64'd0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w_wa_reg    <= w_wa_next;
            w_wb_reg    <= w_wb_next;
            w_side_reg  <= sn_side_reg[CS-1];
            m_small_reg <= w_side_reg.fallback;
            s_small_reg <= m_small_reg;
            q_small_reg <= s_small_reg;
            for (int k = 0; k < 4; k++)
            begin
                m_pa_reg[k] <= m_pa_next[k];
                m_pb_reg[k] <= m_pb_next[k];
                s_r_reg[k]  <= s_sum[k][65:32];
                q_r_reg[k]  <= s_r_reg[k];
                q_sq_reg[k] <= q_full[k][63:0];
            end
            u_sumsq_reg <= u_sum_next;
            u_back_reg  <= u_back_next;
        end
    end

    // Norm as the square root of the sum of squares.
    logic [63:0] sq2_rad [SQ+1];
    logic [63:0] sq2_root [SQ+1];
    qs_pkg::back_t sq2_back_reg [SQ];

    assign sq2_rad[0]  = u_sumsq_reg;
    assign sq2_root[0] = '0;

    for (genvar k = 0; k < SQ; k++)
    begin : g_sq2
        qs_sqrt_cell u_cell (
            .clk      (clk),
            .en       (adv),
            .rad_in   (sq2_rad[k]),
            .root_in  (sq2_root[k]),
            .bit_in   (qs_pkg::sqrt_bit(k)),
            .rad_out  (sq2_rad[k+1]),
            .root_out (sq2_root[k+1])
        );
        if (k == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    sq2_back_reg[k] <= u_back_reg;
                end
            end
        end
        else
        begin : g_rest
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    sq2_back_reg[k] <= sq2_back_reg[k-1];
                end
            end
        end
    end

    // Divider set-up: magnitude scaled to the output format plus half the norm.
    logic [32:0] d0_den_next, d0_den_reg;
    logic [63:0] d0_num_next [4];
    logic [63:0] d0_num_reg [4];
    logic signed [33:0] d0_rk [4];
    logic [33:0] d0_mag [4];
    qs_pkg::tail_t d0_tail_next, d0_tail_reg;

    always_comb
    begin
        d0_den_next = sq2_root[SQ][32:0];
        for (int k = 0; k < 4; k++)
        begin
            d0_rk[k]           = $signed(sq2_back_reg[SQ-1].r[k]);
            d0_mag[k]          = d0_rk[k][33] ? 34'(-d0_rk[k]) : 34'(d0_rk[k]);
            d0_num_next[k]     = (64'(d0_mag[k]) << qs_pkg::FRAC_BITS)
                               + 64'(d0_den_next >> 1);
            d0_tail_next.neg[k] = d0_rk[k][33];
        end
        d0_tail_next.fallback = sq2_back_reg[SQ-1].fallback;
        d0_tail_next.zero     = sq2_back_reg[SQ-1].zero;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d0_den_reg  <= d0_den_next;
            d0_tail_reg <= d0_tail_next;
            for (int k = 0; k < 4; k++)
            begin
                d0_num_reg[k] <= d0_num_next[k];
            end
        end
    end

    // Four divider lanes, one quotient bit per cell, most significant first.
    logic [63:0]   dv_rem [4][CB+1];
    logic [32:0]   dv_den [4][CB+1];
    logic [CB-1:0] dv_quo [4][CB+1];
    qs_pkg::tail_t dv_tail_reg [CB];

    for (genvar ln = 0; ln < 4; ln++)
    begin : g_lane
        assign dv_rem[ln][0] = d0_num_reg[ln];
        assign dv_den[ln][0] = d0_den_reg;
        assign dv_quo[ln][0] = '0;
        for (genvar k = 0; k < CB; k++)
        begin : g_cell
            qs_div_cell u_cell (
                .clk     (clk),
                .en      (adv),
                .step    (qs_pkg::DSTEP_W'(CB - 1 - k)),
                .rem_in  (dv_rem[ln][k]),
                .den_in  (dv_den[ln][k]),
                .quo_in  (dv_quo[ln][k]),
                .rem_out (dv_rem[ln][k+1]),
                .den_out (dv_den[ln][k+1]),
                .quo_out (dv_quo[ln][k+1])
            );
        end
    end

    for (genvar k = 0; k < CB; k++)
    begin : g_tail
        if (k == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    dv_tail_reg[k] <= d0_tail_reg;
                end
            end
        end
        else
        begin : g_rest
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    dv_tail_reg[k] <= dv_tail_reg[k-1];
                end
            end
        end
    end

    // Output register: sign restored, zero-length result forced to zeros.
    logic [CB-1:0] o_comp_next [4];
    logic [CB-1:0] o_comp_reg [4];
    qs_pkg::status_t o_status_next, o_status_reg;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            if (dv_tail_reg[CB-1].zero)
            begin
                o_comp_next[k] = '0;
            end
            else if (dv_tail_reg[CB-1].neg[k])
            begin
                o_comp_next[k] = -dv_quo[k][CB];
            end
            else
            begin
                o_comp_next[k] = dv_quo[k][CB];
            end
        end
        if (dv_tail_reg[CB-1].zero)
        begin
            o_status_next = qs_pkg::STATUS_ZERO;
        end
        else if (dv_tail_reg[CB-1].fallback)
        begin
            o_status_next = qs_pkg::STATUS_SMALL;
        end
        else
        begin
            o_status_next = qs_pkg::STATUS_NORMAL;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            o_status_reg <= o_status_next;
            for (int k = 0; k < 4; k++)
            begin
                o_comp_reg[k] <= o_comp_next[k];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = $signed(o_comp_reg[0]);
    assign out_y     = $signed(o_comp_reg[1]);
    assign out_z     = $signed(o_comp_reg[2]);
    assign out_w     = $signed(o_comp_reg[3]);
    assign status    = o_status_reg;

    // A zero-length result must carry all-zero components.
    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == qs_pkg::STATUS_ZERO
        |-> out_x == '0 && out_y == '0 && out_z == '0 && out_w == '0)
        else $error("zero-norm result with nonzero components");

    // A normalized component never exceeds one in magnitude.
    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid
        |-> out_x <= Q_ONE && out_x >= -Q_ONE && out_y <= Q_ONE && out_y >= -Q_ONE
            && out_z <= Q_ONE && out_z >= -Q_ONE && out_w <= Q_ONE && out_w >= -Q_ONE)
        else $error("normalized component out of range");

    // A taken result with nothing behind it leaves the output empty.
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !vld_reg[LAT-1] |=> !out_valid)
        else $error("result repeated after being taken");

endmodule
